/* hdl/gbm_pkg.sv */
// shared types, constants and helper functions for the gbm path step block
package gbm_pkg;

    typedef logic [31:0] price_t;

    localparam int LN2_Q24       = 11629080;
    localparam int TAYLOR_DEGREE = 10;
    localparam int STEP_CAP      = 4096;
    localparam int DEF_MAX_STEPS = 4096;

    // floor(2^56 / LN2_Q24), the q24 ln2 reciprocal, quotient estimate for the ln2 split
    localparam longint LN2_RECIP = (longint'(1) << 56) / LN2_Q24;

    localparam logic [31:0] RST_START_PRICE = 32'd6553600;
    localparam logic [17:0] RST_VOL         = 18'd13107;
    localparam logic [17:0] RST_RATE        = 18'd3277;
    localparam logic [23:0] RST_STEP_TIME   = 24'd16644;
    localparam logic [12:0] RST_PATH_STEPS  = 13'd1008;
    localparam logic [31:0] RST_STRIKE      = 32'd6553600;

    typedef enum logic [2:0] {
        REG_START_PRICE = 3'd0,
        REG_VOL         = 3'd1,
        REG_RATE        = 3'd2,
        REG_STEP_TIME   = 3'd3,
        REG_PATH_STEPS  = 3'd4,
        REG_STRIKE      = 3'd5
    } cfg_reg_t;

    // floor(2^32 / n) for the taylor term divisors
    function automatic logic [31:0] recip(input logic [3:0] n);
        logic [31:0] r;
        case (n)
            4'd2:    r = 32'd2147483648;
            4'd3:    r = 32'd1431655765;
            4'd4:    r = 32'd1073741824;
            4'd5:    r = 32'd858993459;
            4'd6:    r = 32'd715827882;
            4'd7:    r = 32'd613566756;
            4'd8:    r = 32'd536870912;
            4'd9:    r = 32'd477218588;
            4'd10:   r = 32'd429496729;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // arithmetic right shift, rounding half away from zero
    function automatic logic signed [67:0] rnd_shift(input logic signed [67:0] v,
                                                    input int sh);
        logic [67:0] mag;
        logic [67:0] half;
        logic [67:0] res;
        mag  = v[67] ? 68'(-v) : 68'(v);
        half = 68'd1 << (sh - 1);
        res  = (mag + half) >> sh;
        return v[67] ? -$signed(res) : $signed(res);
    endfunction

endpackage

/* hdl/gbm_path_step_call_payoff.sv */
// gbm monte carlo path stepper with european call payoff at path end
// each sample runs from transfer to its price update, and a path start adds the square
// root and drift/diffusion setup; a path result is presented with the final price update,
// which waits for a free output; a new sample waits until the last is through, paced by
// one shared 34x34 multiplier, a reciprocal multiply split by ln2 and a 10-term horner loop
// reset: synchronous active-low, registers take their defaults, path state clears
module gbm_path_step_call_payoff
    import gbm_pkg::*;
#(
    parameter int MAX_STEPS = DEF_MAX_STEPS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_normal_sample,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_term_price,
    output logic [31:0]        m_call_payoff
);

    localparam int LIM_CAP = (MAX_STEPS < STEP_CAP) ? MAX_STEPS : STEP_CAP;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQRT, ST_MU, ST_MLO, ST_MHI, ST_DRIFT, ST_DIFF, ST_XMUL,
        ST_X, ST_DIV, ST_QE, ST_QM, ST_QR, ST_KF, ST_H1, ST_H2, ST_H3, ST_H4,
        ST_SCALE
    } state_t;

    state_t state_reg;

    logic [31:0]        start_price_reg;
    logic [17:0]        vol_reg;
    logic signed [17:0] rate_reg;
    logic [23:0]        step_time_reg;
    logic [12:0]        path_steps_reg;
    logic [31:0]        strike_reg;

    price_t             price_reg;
    logic [12:0]        count_reg;
    logic signed [31:0] drift_reg;
    logic [31:0]        diff_reg;

    logic signed [15:0] z_reg;
    logic [47:0]        sq_n_reg;
    logic [47:0]        sq_res_reg;
    logic [47:0]        sq_bit_reg;
    logic [4:0]         iter_reg;
    logic signed [37:0] mu_reg;
    logic signed [67:0] lo_reg;
    logic               x_neg_reg;
    logic [35:0]        rem_reg;
    logic [11:0]        q_reg;
    logic signed [12:0] k_reg;
    logic [29:0]        f30_reg;
    logic [31:0]        acc_reg;
    logic [3:0]         n_reg;
    logic [32:0]        v_reg;
    logic signed [67:0] prod_reg;
    logic               pmul_reg;

    logic               m_valid_reg;
    logic [31:0]        m_term_price_reg;
    logic [31:0]        m_call_payoff_reg;

    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic [47:0]        sq_sum;
    logic signed [67:0] zd_rnd;
    logic signed [67:0] drift_rnd;
    logic signed [67:0] diff_rnd;
    logic signed [33:0] x_val;
    logic [12:0]        lim;
    logic [12:0]        count_next;
    logic               res_load;
    logic [11:0]        q_fix;
    logic [35:0]        rem_fix;
    logic [31:0]        t_val;
    logic [32:0]        q_est;
    logic [36:0]        r_val;
    price_t             price_next;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SQRT: begin
                mul_a = {16'd0, vol_reg};
                mul_b = {16'd0, vol_reg};
            end
            ST_MLO: begin
                mul_a = {15'd0, mu_reg[18:0]};
                mul_b = {10'd0, step_time_reg};
            end
            ST_MHI: begin
                mul_a = {{15{mu_reg[37]}}, mu_reg[37:19]};
                mul_b = {10'd0, step_time_reg};
            end
            ST_DRIFT: begin
                mul_a = {16'd0, vol_reg};
                mul_b = {10'd0, sq_res_reg[23:0]};
            end
            ST_XMUL: begin
                mul_a = {2'd0, diff_reg};
                mul_b = {{18{z_reg[15]}}, z_reg};
            end
            ST_DIV: begin
                mul_a = {2'd0, rem_reg[31:0]};
                mul_b = 34'(LN2_RECIP);
            end
            ST_QM: begin
                mul_a = {22'd0, q_reg};
                mul_b = 34'(LN2_Q24);
            end
            ST_H1, ST_SCALE: begin
                mul_a = pmul_reg ? {2'd0, price_reg} : {2'd0, acc_reg};
                mul_b = pmul_reg ? {2'd0, acc_reg} : {4'd0, f30_reg};
            end
            ST_H3: begin
                mul_a = {1'b0, v_reg};
                mul_b = {2'd0, recip(n_reg)};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        sq_sum     = sq_res_reg + sq_bit_reg;
        zd_rnd     = rnd_shift(prod_reg, 12);
        drift_rnd  = rnd_shift(lo_reg + (prod_reg <<< 19), 33);
        diff_rnd   = rnd_shift(prod_reg, 16);
        x_val      = {{2{drift_reg[31]}}, drift_reg} + zd_rnd[33:0];
        lim        = (path_steps_reg == 13'd0) ? 13'd1 : path_steps_reg;
        if (lim > 13'(LIM_CAP)) begin
            lim = 13'(LIM_CAP);
        end
        count_next = count_reg + 13'd1;
        res_load   = (state_reg == ST_SCALE) && (count_next >= lim)
                     && (!m_valid_reg || m_ready);
        q_fix      = (rem_reg >= 36'(LN2_Q24)) ? q_reg + 12'd1 : q_reg;
        rem_fix    = (rem_reg >= 36'(LN2_Q24)) ? rem_reg - 36'(LN2_Q24) : rem_reg;
        t_val      = 32'((prod_reg[63:0] + 64'd536870912) >> 30);
        q_est      = prod_reg[64:32];
        r_val      = {4'd0, v_reg} - 37'(q_est * n_reg);
    end

    gbm_scale u_scale (
        .prod  (prod_reg[63:0]),
        .k     (k_reg),
        .price (price_next)
    );

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            start_price_reg <= RST_START_PRICE;
            vol_reg         <= RST_VOL;
            rate_reg        <= RST_RATE;
            step_time_reg   <= RST_STEP_TIME;
            path_steps_reg  <= RST_PATH_STEPS;
            strike_reg      <= RST_STRIKE;
            price_reg       <= '0;
            count_reg       <= '0;
            drift_reg       <= '0;
            diff_reg        <= '0;
            m_valid_reg     <= 1'b0;
            pmul_reg        <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_START_PRICE: start_price_reg <= cfg_wr_data;
                    REG_VOL:         vol_reg         <= cfg_wr_data[17:0];
                    REG_RATE:        rate_reg        <= cfg_wr_data[17:0];
                    REG_STEP_TIME:   step_time_reg   <= cfg_wr_data[23:0];
                    REG_PATH_STEPS:  path_steps_reg  <= cfg_wr_data[12:0];
                    REG_STRIKE:      strike_reg      <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        z_reg <= s_normal_sample;
                        if (count_reg == 13'd0) begin
                            price_reg  <= start_price_reg;
                            sq_n_reg   <= {step_time_reg, 24'd0};
                            sq_res_reg <= '0;
                            sq_bit_reg <= 48'd1 << 46;
                            iter_reg   <= '0;
                            state_reg  <= ST_SQRT;
                        end else begin
                            state_reg <= ST_XMUL;
                        end
                    end
                end
                ST_SQRT: begin
                    if (sq_n_reg >= sq_sum) begin
                        sq_n_reg   <= sq_n_reg - sq_sum;
                        sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                    end else begin
                        sq_res_reg <= sq_res_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                    iter_reg   <= iter_reg + 5'd1;
                    if (iter_reg == 5'd23) begin
                        state_reg <= ST_MU;
                    end
                end
                ST_MU: begin
                    mu_reg    <= {{3{rate_reg[17]}}, rate_reg, 17'd0}
                                 - {2'd0, prod_reg[35:0]};
                    state_reg <= ST_MLO;
                end
                ST_MLO: begin
                    state_reg <= ST_MHI;
                end
                ST_MHI: begin
                    lo_reg    <= prod_reg;
                    state_reg <= ST_DRIFT;
                end
                ST_DRIFT: begin
                    drift_reg <= drift_rnd[31:0];
                    state_reg <= ST_DIFF;
                end
                ST_DIFF: begin
                    diff_reg  <= diff_rnd[31:0];
                    state_reg <= ST_XMUL;
                end
                ST_XMUL: begin
                    state_reg <= ST_X;
                end
                ST_X: begin
                    x_neg_reg <= x_val[33];
                    rem_reg   <= {2'd0, x_val[33] ? 34'(-x_val) : 34'(x_val)};
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    state_reg <= ST_QE;
                end
                ST_QE: begin
                    q_reg     <= prod_reg[67:56];
                    state_reg <= ST_QM;
                end
                ST_QM: begin
                    state_reg <= ST_QR;
                end
                ST_QR: begin
                    rem_reg   <= rem_reg - prod_reg[35:0];
                    state_reg <= ST_KF;
                end
                ST_KF: begin
                    if (!x_neg_reg) begin
                        k_reg   <= {1'b0, q_fix};
                        f30_reg <= {rem_fix[23:0], 6'd0};
                    end else if (rem_fix == 36'd0) begin
                        k_reg   <= -$signed({1'b0, q_fix});
                        f30_reg <= '0;
                    end else begin
                        k_reg   <= -$signed({1'b0, q_fix} + 13'd1);
                        f30_reg <= {24'(36'(LN2_Q24) - rem_fix), 6'd0};
                    end
                    acc_reg   <= 32'd1 << 30;
                    n_reg     <= 4'(TAYLOR_DEGREE);
                    pmul_reg  <= 1'b0;
                    state_reg <= ST_H1;
                end
                ST_H1: begin
                    state_reg <= pmul_reg ? ST_SCALE : ST_H2;
                end
                ST_H2: begin
                    if (n_reg == 4'd1) begin
                        acc_reg   <= (32'd1 << 30) + t_val;
                        pmul_reg  <= 1'b1;
                        state_reg <= ST_H1;
                    end else begin
                        v_reg     <= {1'b0, t_val} + 33'(n_reg >> 1);
                        state_reg <= ST_H3;
                    end
                end
                ST_H3: begin
                    state_reg <= ST_H4;
                end
                ST_H4: begin
                    if (r_val >= {33'd0, n_reg}) begin
                        acc_reg <= (32'd1 << 30) + 32'(q_est + 33'd1);
                    end else begin
                        acc_reg <= (32'd1 << 30) + q_est[31:0];
                    end
                    n_reg     <= n_reg - 4'd1;
                    state_reg <= ST_H1;
                end
                ST_SCALE: begin
                    if (count_next >= lim) begin
                        if (res_load) begin
                            price_reg         <= price_next;
                            count_reg         <= '0;
                            m_term_price_reg  <= price_next;
                            m_call_payoff_reg <= (price_next > strike_reg)
                                                 ? price_next - strike_reg : 32'd0;
                            state_reg         <= ST_IDLE;
                        end
                    end else begin
                        price_reg <= price_next;
                        count_reg <= count_next;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_term_price  = m_term_price_reg;
    assign m_call_payoff = m_call_payoff_reg;

endmodule

/* hdl/gbm_scale.sv */
// rounding, saturating power-of-two scale of the price product
module gbm_scale
    import gbm_pkg::*;
(
    input  logic [63:0]        prod,
    input  logic signed [12:0] k,
    output price_t             price
);

    logic signed [13:0] sh;
    logic [13:0]        ls;
    logic [95:0]        pl;
    logic [64:0]        pr;

    always_comb begin
        sh = 14'sd30 - {k[12], k};
        ls = 14'(-sh);
        pl = {32'd0, prod} << ls[4:0];
        pr = ({1'b0, prod} + (65'd1 << (sh[5:0] - 6'd1))) >> sh[5:0];
        if (prod == 64'd0) begin
            price = '0;
        end else if (sh <= 14'sd0) begin
            if (ls >= 14'd32 || pl[95:32] != 64'd0) begin
                price = '1;
            end else begin
                price = pl[31:0];
            end
        end else if (sh >= 14'sd64) begin
            price = '0;
        end else if (pr[64:32] != 33'd0) begin
            price = '1;
        end else begin
            price = pr[31:0];
        end
    end

endmodule

/* bench/tb_gbm_path_step_call_payoff.sv */
// testbench for the gbm path stepper: directed and random draws and settings checked against a bit-exact predictor
module tb_gbm_path_step_call_payoff
    import gbm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] term_price;
        logic [31:0] call_payoff;
    } path_result_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_normal_sample;
    logic               m_valid;
    logic               m_ready;
    logic [31:0]        m_term_price;
    logic [31:0]        m_call_payoff;

    // model copy of the registers and path state
    logic [31:0] md_start_price;
    logic [17:0] md_vol;
    logic [17:0] md_rate;
    logic [23:0] md_step_time;
    logic [12:0] md_path_steps;
    logic [31:0] md_strike;
    logic [31:0] md_price = '0;
    logic [12:0] md_step_count = '0;
    logic [31:0] md_drift = '0;
    logic [31:0] md_diffusion = '0;

    logic signed [15:0] draw_queue[$];
    path_result_t       payoff_queue[$];
    int                 errors = 0;
    int                 results_seen = 0;
    int                 hold_cnt = 0;
    logic               quiet;

    gbm_path_step_call_payoff uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_normal_sample(s_normal_sample),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_term_price(m_term_price), .m_call_payoff(m_call_payoff)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic longint round_away(longint v, int sh);
        longint half;
        half = longint'(1) <<< (sh - 1);
        if (v < 0)
            return -(((-v) + half) >>> sh);
        return (v + half) >>> sh;
    endfunction

    function automatic longint unsigned isqrt_q24(logic [23:0] t);
        longint unsigned n;
        longint unsigned res;
        longint unsigned b;
        n = longint'(t) << 24;
        res = 0;
        for (int i = 0; i < 24; i++) begin
            b = longint'(1) << (46 - 2 * i);
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
        end
        return res;
    endfunction

    function automatic logic [31:0] grow_price(logic [31:0] price, longint x);
        longint k;
        longint f;
        longint s;
        longint unsigned f30;
        longint unsigned acc;
        longint unsigned t;
        longint unsigned p;
        if (x >= 0)
            k = x / LN2_Q24;
        else
            k = -((-x + LN2_Q24 - 1) / LN2_Q24);
        f = x - k * LN2_Q24;
        f30 = longint'(f) << 6;
        acc = longint'(1) << 30;
        for (int n = TAYLOR_DEGREE; n >= 1; n--) begin
            t = (acc * f30 + (longint'(1) << 29)) >> 30;
            acc = (longint'(1) << 30) + (t + longint'(n / 2)) / longint'(n);
        end
        p = longint'(price) * acc;
        if (p == 0)
            return 32'd0;
        s = 30 - k;
        if (s <= 0) begin
            if (-s >= 32 || p > (64'hFFFF_FFFF >> (-s)))
                return 32'hFFFF_FFFF;
            return 32'(p << (-s));
        end
        if (s >= 64)
            return 32'd0;
        p = (p + (longint'(1) << (s - 1))) >> s;
        return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(p);
    endfunction

    task automatic advance_path(logic signed [15:0] z);
        longint      r;
        longint      mu;
        longint      x;
        int unsigned lim;
        path_result_t res;
        lim = md_path_steps;
        if (lim == 0)
            lim = 1;
        if (lim > STEP_CAP)
            lim = STEP_CAP;
        if (md_step_count == 0) begin
            r = longint'($signed(md_rate));
            mu = r * 131072 - longint'(md_vol) * longint'(md_vol);
            md_price = md_start_price;
            md_drift = 32'(round_away(mu * longint'(md_step_time), 33));
            md_diffusion = 32'(round_away(longint'(md_vol) * longint'(isqrt_q24(md_step_time)), 16));
        end
        x = longint'($signed(md_drift)) + round_away(longint'(md_diffusion) * longint'(z), 12);
        md_price = grow_price(md_price, x);
        md_step_count = md_step_count + 13'd1;
        if (md_step_count >= lim) begin
            md_step_count = 0;
            res.term_price = md_price;
            res.call_payoff = (md_price > md_strike) ? md_price - md_strike : 32'd0;
            payoff_queue.push_back(res);
        end
    endtask

    // driver
    always @(posedge aclk) begin : drive_draws
        logic go;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                advance_path(s_normal_sample);
            if (!s_valid || s_ready) begin
                go = quiet || ($urandom_range(0, 99) >= 29);
                if (go && draw_queue.size() > 0) begin
                    s_valid <= 1'b1;
                    s_normal_sample <= draw_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin : check_payoffs
        path_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen = results_seen + 1;
                if (payoff_queue.size() == 0) begin
                    $display("%0t: unexpected transfer price %h payoff %h",
                             $time, m_term_price, m_call_payoff);
                    errors = errors + 1;
                end else begin
                    want = payoff_queue.pop_front();
                    if (m_term_price !== want.term_price) begin
                        $display("%0t: term_price expected %h actual %h",
                                 $time, want.term_price, m_term_price);
                        errors = errors + 1;
                    end
                    if (m_call_payoff !== want.call_payoff) begin
                        $display("%0t: call_payoff expected %h actual %h",
                                 $time, want.call_payoff, m_call_payoff);
                        errors = errors + 1;
                    end
                end
                // long hold-off so the block backs up into its input
                if (results_seen == 30)
                    hold_cnt = 900;
            end
            if (hold_cnt > 0) begin
                hold_cnt = hold_cnt - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= quiet || ($urandom_range(0, 99) >= 29);
            end
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        case (idx)
            REG_START_PRICE: md_start_price = val;
            REG_VOL:         md_vol = val[17:0];
            REG_RATE:        md_rate = val[17:0];
            REG_STEP_TIME:   md_step_time = val[23:0];
            REG_PATH_STEPS:  md_path_steps = val[12:0];
            REG_STRIKE:      md_strike = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        while (draw_queue.size() > 0 || s_valid || payoff_queue.size() > 0)
            @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    task automatic write_all(logic [31:0] sp, logic [31:0] v, logic [31:0] r,
                             logic [31:0] st, logic [31:0] ps, logic [31:0] k);
        write_reg(REG_START_PRICE, sp);
        write_reg(REG_VOL, v);
        write_reg(REG_RATE, r);
        write_reg(REG_STEP_TIME, st);
        write_reg(REG_PATH_STEPS, ps);
        write_reg(REG_STRIKE, k);
    endtask

    function automatic logic signed [15:0] pick_draw();
        if ($urandom_range(0, 9) < 2)
            return 16'($urandom());
        return 16'($signed($urandom_range(0, 16383)) - 8192);
    endfunction

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wr_data = '0;
        quiet = 1'b0;
        md_start_price = RST_START_PRICE;
        md_vol = RST_VOL;
        md_rate = RST_RATE;
        md_step_time = RST_STEP_TIME;
        md_path_steps = RST_PATH_STEPS;
        md_strike = RST_STRIKE;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // default settings, one step per path, extreme draws
        write_reg(REG_PATH_STEPS, 32'd1);
        draw_queue = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0001, -16'sh0001};
        wait_idle();

        // overflow to saturation, zero length path
        write_all(32'hFFFF_FFFF, 32'h3FFFF, 32'h1FFFF, 32'd16644, 32'd0, 32'd0);
        draw_queue = '{16'sh7fff, 16'sh8000, 16'sh0100};
        wait_idle();

        // price collapses to zero and stays there
        write_all(32'd1, 32'd0, 32'h20000, 32'hFF_FFFF, 32'd2, 32'hFFFF_FFFF);
        draw_queue = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh0000};
        wait_idle();
        write_reg(REG_STEP_TIME, 32'd1);
        write_reg(REG_START_PRICE, 32'd6553600);
        draw_queue = '{16'sh1000, -16'sh1000};
        wait_idle();

        // clamped long path, then shortened mid-path
        write_all(32'd6553600, 32'd13107, 32'd3277, 32'd16644, 32'h1FFF, 32'd6553600);
        draw_queue = '{16'sh0800, -16'sh0800, 16'sh0400, 16'sh7fff, 16'sh8000};
        wait_idle();
        write_reg(REG_STRIKE, 32'd0);
        write_reg(REG_PATH_STEPS, 32'd3);
        draw_queue = '{16'sh0200};
        wait_idle();
        write_reg(REG_PATH_STEPS, 32'd4096);
        write_reg(REG_PATH_STEPS, 32'd1);
        draw_queue = '{16'sh0000};
        wait_idle();

        for (int ph = 0; ph < 14; ph++) begin
            quiet = (ph == 4);
            if (ph % 2 == 0) begin
                write_all($urandom_range(32'd655360, 32'd13107200), $urandom_range(0, 40000),
                          32'($signed($urandom_range(0, 20000)) - 10000),
                          $urandom_range(1000, 300000), $urandom_range(1, 10),
                          $urandom_range(32'd655360, 32'd13107200));
            end else begin
                write_all($urandom(), $urandom() & 32'h3FFFF, $urandom() & 32'h3FFFF,
                          ($urandom() & 32'hFF_FFFF) | 32'd1, $urandom_range(0, 16),
                          $urandom());
            end
            for (int i = 0; i < 130; i++)
                draw_queue.push_back(pick_draw());
            wait_idle();
        end
        quiet = 1'b0;

        while (payoff_queue.size() > 0)
            @(posedge aclk);
        repeat (120) @(posedge aclk);
        if (errors == 0 && payoff_queue.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
